/* rtl/core/lkt_pkg.sv */
// Shared constants, types and control structs for the latency top-K tracker.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package lkt_pkg;

  localparam int unsigned NUM_KEYS    = 16;
  localparam int unsigned K_SLOTS     = 8;
  localparam int unsigned SAMPLE_BITS = 32;

  // Fixed field widths
  localparam int unsigned KEY_W = 4;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 64;

  localparam int unsigned KEY_IW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned SLOT_IW   = (K_SLOTS > 1) ? $clog2(K_SLOTS) : 1;
  localparam int unsigned SCAN_W    = $clog2(2 * K_SLOTS + 1);
  localparam int unsigned SET_AW    = KEY_IW + SLOT_IW + 1;
  localparam int unsigned SET_DEPTH = 2 ** SET_AW;
  localparam int unsigned STAT_W    = SUM_W + CNT_W;

  localparam logic [VAL_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= 32) ? '1 : VAL_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Which half of the set memory a word lives in
  localparam logic HALF_SMALL = 1'b0;
  localparam logic HALF_LARGE = 1'b1;

  typedef struct packed {
    logic               clr;
    logic               rd_en;
    logic               wr_en;
    logic [SLOT_IW-1:0] slot;
    logic               half;
    logic               fill;
    logic [SLOT_IW-1:0] fill_slot;
  } set_ctrl_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [KEY_IW-1:0] rd_idx;
    logic [KEY_IW-1:0] wr_idx;
  } stat_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/lkt_stat_unit.sv */
// Per-key saturating count and sum, kept in a small synchronous memory.
// Depends on lkt_pkg.
`default_nettype none

module lkt_stat_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkt_pkg::stat_ctrl_t       ctrl_i,
  input  logic [lkt_pkg::VAL_W-1:0] smp_i,
  output logic [lkt_pkg::CNT_W-1:0] old_cnt_o,
  output logic [lkt_pkg::CNT_W-1:0] new_cnt_o,
  output logic [lkt_pkg::SUM_W-1:0] new_sum_o
);
  import lkt_pkg::*;

  logic [STAT_W-1:0]   mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld_q;
  logic [STAT_W-1:0]   rdata_q;
  logic                rvld_q;
  logic [SUM_W-1:0]    old_sum;
  logic [SUM_W:0]      sum_ext;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[ctrl_i.rd_idx];
    end
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_idx] <= {new_sum_o, new_cnt_o};
    end
  end

  // Valid bits stand in for the zero reset of the memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctrl_i.rd_en) begin
        rvld_q <= vld_q[ctrl_i.rd_idx];
      end
      if (ctrl_i.wr_en) begin
        vld_q[ctrl_i.wr_idx] <= 1'b1;
      end
    end
  end

  assign old_cnt_o = rvld_q ? rdata_q[CNT_W-1:0] : '0;
  assign old_sum   = rvld_q ? rdata_q[STAT_W-1:CNT_W] : '0;
  assign sum_ext   = (SUM_W + 1)'(old_sum) + (SUM_W + 1)'(smp_i);
  assign new_sum_o = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign new_cnt_o = (old_cnt_o == '1) ? old_cnt_o : old_cnt_o + CNT_W'(1);

endmodule

`default_nettype wire

/* rtl/core/lkt_set_unit.sv */
// K-smallest / K-largest set memory with its scan accumulators and write-back.
// Depends on lkt_pkg.
`default_nettype none

module lkt_set_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkt_pkg::set_ctrl_t         ctrl_i,
  input  logic [lkt_pkg::KEY_IW-1:0] key_idx_i,
  input  logic [lkt_pkg::VAL_W-1:0]  smp_i,
  output logic [lkt_pkg::VAL_W-1:0]  low_thr_o,
  output logic [lkt_pkg::VAL_W-1:0]  high_thr_o
);
  import lkt_pkg::*;

  logic [VAL_W-1:0]   mem [SET_DEPTH];
  logic [SET_AW-1:0]  rd_addr;
  logic [SET_AW-1:0]  wr_addr;
  logic [SLOT_IW-1:0] wr_slot;
  logic               wr_go;

  logic [VAL_W-1:0]   rdata_q;
  logic               rvld_q;
  logic               rhalf_q;
  logic [SLOT_IW-1:0] rslot_q;
  logic               counted;

  // m1: first extreme and its slot, m2: extreme over all other slots
  logic [VAL_W-1:0]   s_m1_q, s_m2_q, l_m1_q, l_m2_q;
  logic [SLOT_IW-1:0] s_pos_q, l_pos_q;
  logic               repl_s, repl_l;

  assign rd_addr = {key_idx_i, ctrl_i.slot, ctrl_i.half};

  assign repl_s  = smp_i < s_m1_q;
  assign repl_l  = smp_i > l_m1_q;
  assign wr_go   = ctrl_i.wr_en &&
                   (ctrl_i.fill || ((ctrl_i.half == HALF_LARGE) ? repl_l : repl_s));
  assign wr_slot = ctrl_i.fill ? ctrl_i.fill_slot :
                   ((ctrl_i.half == HALF_LARGE) ? l_pos_q : s_pos_q);
  assign wr_addr = {key_idx_i, wr_slot, ctrl_i.half};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr];
      rhalf_q <= ctrl_i.half;
      rslot_q <= ctrl_i.slot;
    end
    if (wr_go) begin
      mem[wr_addr] <= smp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= ctrl_i.rd_en;
    end
  end

  // While filling, only the slots already written take part
  assign counted = rvld_q && (!ctrl_i.fill || (rslot_q < ctrl_i.fill_slot));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      s_m1_q  <= '0;
      s_m2_q  <= '0;
      s_pos_q <= '0;
      l_m1_q  <= '1;
      l_m2_q  <= '1;
      l_pos_q <= '0;
    end else if (counted) begin
      if (rhalf_q == HALF_SMALL) begin
        if (rdata_q > s_m1_q) begin
          s_m2_q  <= s_m1_q;
          s_m1_q  <= rdata_q;
          s_pos_q <= rslot_q;
        end else if (rdata_q > s_m2_q) begin
          s_m2_q <= rdata_q;
        end
      end else begin
        if (rdata_q < l_m1_q) begin
          l_m2_q  <= l_m1_q;
          l_m1_q  <= rdata_q;
          l_pos_q <= rslot_q;
        end else if (rdata_q < l_m2_q) begin
          l_m2_q <= rdata_q;
        end
      end
    end
  end

  always_comb begin
    if (ctrl_i.fill) begin
      low_thr_o  = (smp_i > s_m1_q) ? smp_i : s_m1_q;
      high_thr_o = (smp_i < l_m1_q) ? smp_i : l_m1_q;
    end else begin
      low_thr_o  = !repl_s ? s_m1_q : ((smp_i > s_m2_q) ? smp_i : s_m2_q);
      high_thr_o = !repl_l ? l_m1_q : ((smp_i < l_m2_q) ? smp_i : l_m2_q);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/latency_topk_tracker_core.sv */
// Top level of the latency top-K tracker: control sequencer and result register.
// Depends on lkt_pkg, lkt_stat_unit and lkt_set_unit.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------------
//  command  | key_i, sample_i                           | start & !busy takes a word
//  result   | key_echo_o, sample_count_o, sample_sum_o, | result_valid_o, one cycle,
//           | low_threshold_o, high_threshold_o,        | no back-pressure
//           | sets_full_o                               |
//
// An in-range key keeps busy high through the scan and both write-back states: the
// scan reads both sets of the key through the single read port of the set memory,
// one word a cycle, then the small and large sets are written back. The result strobe follows in the
// first idle cycle. A key at or above NUM_KEYS gives its zero result the next
// cycle and leaves busy low. Reset clears the sequencer and the per-key valid
// bits of the statistics; the set memory needs no clearing.
`default_nettype none

module latency_topk_tracker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [lkt_pkg::KEY_W-1:0] key_i,
  input  logic [lkt_pkg::VAL_W-1:0] sample_i,
  output logic                      result_valid_o,
  output logic [lkt_pkg::KEY_W-1:0] key_echo_o,
  output logic [lkt_pkg::CNT_W-1:0] sample_count_o,
  output logic [lkt_pkg::SUM_W-1:0] sample_sum_o,
  output logic [lkt_pkg::VAL_W-1:0] low_threshold_o,
  output logic [lkt_pkg::VAL_W-1:0] high_threshold_o,
  output logic                      sets_full_o
);
  import lkt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_UPD_S = 2'd2;
  localparam logic [1:0] ST_UPD_L = 2'd3;

  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(2 * K_SLOTS);

  logic [1:0]        state_q, state_d;
  logic [SCAN_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  smp_q;
  logic [KEY_IW-1:0] key_idx;
  logic              accept;
  logic              in_range;

  set_ctrl_t         set_ctrl;
  stat_ctrl_t        stat_ctrl;
  logic [CNT_W-1:0]  old_cnt, new_cnt;
  logic [SUM_W-1:0]  new_sum;
  logic [VAL_W-1:0]  low_thr, high_thr;

  logic              res_vld_q, res_vld_d;
  logic              res_load;
  logic              res_zero;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = 32'(key_i) < NUM_KEYS;
  assign key_idx  = KEY_IW'(key_q);

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    res_vld_d  = 1'b0;
    res_load   = 1'b0;
    res_zero   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        scan_cnt_d = '0;
        if (accept) begin
          if (in_range) begin
            state_d = ST_SCAN;
          end else begin
            res_load  = 1'b1;
            res_zero  = 1'b1;
            res_vld_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // last read word is consumed in the cycle the counter reaches its end
        if (scan_cnt_q == SCAN_END) begin
          state_d = ST_UPD_S;
        end else begin
          scan_cnt_d = scan_cnt_q + SCAN_W'(1);
        end
      end
      ST_UPD_S: begin
        state_d = ST_UPD_L;
      end
      ST_UPD_L: begin
        state_d   = ST_IDLE;
        res_load  = 1'b1;
        res_vld_d = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    set_ctrl.clr       = accept;
    set_ctrl.rd_en     = (state_q == ST_SCAN) && (scan_cnt_q != SCAN_END);
    set_ctrl.wr_en     = (state_q == ST_UPD_S) || (state_q == ST_UPD_L);
    set_ctrl.slot      = SLOT_IW'(scan_cnt_q >> 1);
    set_ctrl.half      = (state_q == ST_UPD_L) ? HALF_LARGE :
                         (state_q == ST_UPD_S) ? HALF_SMALL : scan_cnt_q[0];
    set_ctrl.fill      = old_cnt < CNT_W'(K_SLOTS);
    set_ctrl.fill_slot = SLOT_IW'(old_cnt);

    stat_ctrl.rd_en  = accept && in_range;
    stat_ctrl.wr_en  = (state_q == ST_UPD_S);
    stat_ctrl.rd_idx = KEY_IW'(key_i);
    stat_ctrl.wr_idx = key_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_i;
      smp_q <= sample_i & SAMPLE_MASK;
    end
    if (res_load) begin
      if (res_zero) begin
        key_echo_o       <= key_i;
        sample_count_o   <= '0;
        sample_sum_o     <= '0;
        low_threshold_o  <= '0;
        high_threshold_o <= '0;
        sets_full_o      <= 1'b0;
      end else begin
        key_echo_o       <= key_q;
        sample_count_o   <= new_cnt;
        sample_sum_o     <= new_sum;
        low_threshold_o  <= low_thr;
        high_threshold_o <= high_thr;
        sets_full_o      <= new_cnt >= CNT_W'(K_SLOTS);
      end
    end
  end

  assign result_valid_o = res_vld_q;

  lkt_stat_unit u_stat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (stat_ctrl),
    .smp_i     (smp_q),
    .old_cnt_o (old_cnt),
    .new_cnt_o (new_cnt),
    .new_sum_o (new_sum)
  );

  lkt_set_unit u_set (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (set_ctrl),
    .key_idx_i  (key_idx),
    .smp_i      (smp_q),
    .low_thr_o  (low_thr),
    .high_thr_o (high_thr)
  );

endmodule

`default_nettype wire

/* rtl/core/lkt_checker.sv */
// Port-level checks for latency_topk_tracker_core, bound onto the top level.
// Depends on lkt_pkg.
`default_nettype none

module lkt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [lkt_pkg::KEY_W-1:0] key_i,
  input logic                      result_valid_o,
  input logic [lkt_pkg::CNT_W-1:0] sample_count_o,
  input logic [lkt_pkg::VAL_W-1:0] low_threshold_o,
  input logic [lkt_pkg::VAL_W-1:0] high_threshold_o,
  input logic                      sets_full_o
);
  import lkt_pkg::*;

  // a result word only shows while the core is idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_inrange_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (32'(key_i) < NUM_KEYS)) |=> busy)
    else $error("in-range command did not start a scan");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("scan ended without a result word");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (sets_full_o == (sample_count_o >= CNT_W'(K_SLOTS))))
    else $error("sets_full disagrees with count");

  // before the sets fill up both sets hold the same samples
  a_thr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !sets_full_o) |-> (low_threshold_o >= high_threshold_o))
    else $error("thresholds out of order while filling");

endmodule

bind latency_topk_tracker_core lkt_checker u_lkt_checker (.*);

`default_nettype wire

/* tb/latency_topk_tracker_core_tb.sv */
// Self-checking testbench for latency_topk_tracker_core: a directed table, then random words;
// typed rows check their table values, the rest a per-key statistics predictor in the bench.
// Depends on lkt_pkg and the RTL under rtl/core.
module latency_topk_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkt_pkg::*;

  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 2 * K_SLOTS + 8;

  typedef struct packed {
    logic [KEY_W-1:0] key_echo;
    logic [CNT_W-1:0] sample_count;
    logic [SUM_W-1:0] sample_sum;
    logic [VAL_W-1:0] low_threshold;
    logic [VAL_W-1:0] high_threshold;
    logic             sets_full;
  } stat_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] sample;
    logic             typed;
    stat_word_t       want;
  } cmd_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [KEY_W-1:0] key_i;
  logic [VAL_W-1:0] sample_i;
  logic             result_valid_o;
  logic [KEY_W-1:0] key_echo_o;
  logic [CNT_W-1:0] sample_count_o;
  logic [SUM_W-1:0] sample_sum_o;
  logic [VAL_W-1:0] low_threshold_o;
  logic [VAL_W-1:0] high_threshold_o;
  logic             sets_full_o;

  // predictor state
  logic [VAL_W-1:0] small_slots [NUM_KEYS][K_SLOTS];
  logic [VAL_W-1:0] large_slots [NUM_KEYS][K_SLOTS];
  logic [SUM_W-1:0] seen_sum    [NUM_KEYS];
  logic [CNT_W-1:0] seen_count  [NUM_KEYS];

  stat_word_t  pending_stats [$];
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  cmd_row_t    directed_rows [18];

  latency_topk_tracker_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .key_i            (key_i),
    .sample_i         (sample_i),
    .result_valid_o   (result_valid_o),
    .key_echo_o       (key_echo_o),
    .sample_count_o   (sample_count_o),
    .sample_sum_o     (sample_sum_o),
    .low_threshold_o  (low_threshold_o),
    .high_threshold_o (high_threshold_o),
    .sets_full_o      (sets_full_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic stat_word_t update_key_stats(logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] raw);
    stat_word_t       w;
    logic [VAL_W-1:0] s;
    logic [SUM_W:0]   acc;
    int unsigned      n;
    int unsigned      fill;
    int unsigned      hit;
    int unsigned      i;
    s = raw & SAMPLE_MASK;
    w = '0;
    w.key_echo = key;
    if (key >= NUM_KEYS) return w;
    n = seen_count[key];
    if (n < K_SLOTS) begin
      small_slots[key][n] = s;
      large_slots[key][n] = s;
    end else begin
      // first slot holding the extreme wins on ties
      hit = 0;
      for (i = 1; i < K_SLOTS; i++)
        if (small_slots[key][i] > small_slots[key][hit]) hit = i;
      if (s < small_slots[key][hit]) small_slots[key][hit] = s;
      hit = 0;
      for (i = 1; i < K_SLOTS; i++)
        if (large_slots[key][i] < large_slots[key][hit]) hit = i;
      if (s > large_slots[key][hit]) large_slots[key][hit] = s;
    end
    acc = {1'b0, seen_sum[key]} + {{(SUM_W+1-VAL_W){1'b0}}, s};
    seen_sum[key] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
    if (seen_count[key] != '1) seen_count[key] = seen_count[key] + 1'b1;
    w.sample_count = seen_count[key];
    w.sample_sum   = seen_sum[key];
    fill = (seen_count[key] < K_SLOTS) ? seen_count[key] : K_SLOTS;
    w.low_threshold  = small_slots[key][0];
    w.high_threshold = large_slots[key][0];
    for (i = 1; i < fill; i++) begin
      if (small_slots[key][i] > w.low_threshold) w.low_threshold = small_slots[key][i];
      if (large_slots[key][i] < w.high_threshold) w.high_threshold = large_slots[key][i];
    end
    w.sets_full = (seen_count[key] >= K_SLOTS);
    return w;
  endfunction

  function automatic void report_field(string field, logic [SUM_W-1:0] want,
                                       logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t ERROR %s: expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Drives one word and returns at the edge that takes it; start stays high.
  task automatic send_word(logic [KEY_W-1:0] key, logic [VAL_W-1:0] sample,
                           logic typed, stat_word_t want);
    stat_word_t predicted;
    start    <= 1'b1;
    key_i    <= key;
    sample_i <= sample;
    do @(posedge clk_i); while (busy);
    predicted = update_key_stats(key, sample);
    pending_stats.push_back(typed ? want : predicted);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_sample();
    case ($urandom_range(0, 9)) inside
      0:       return '0;
      1:       return '1;
      [2:4]:   return $urandom_range(0, 15);  // narrow range, many ties
      [5:6]:   return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    // a few hot keys run deep into replace mode
    if ($urandom_range(0, 9) < 7) return KEY_W'($urandom_range(0, 3));
    return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  always @(posedge clk_i) begin
    stat_word_t got;
    if (rst_ni && result_valid_o) begin
      got = '{key_echo_o, sample_count_o, sample_sum_o, low_threshold_o,
              high_threshold_o, sets_full_o};
      if (pending_stats.size() == 0) begin
        $display("%0t ERROR unexpected result word: expected none, got key %0h",
                 $time, key_echo_o);
        mismatch_count++;
      end else begin
        stat_word_t want;
        want = pending_stats.pop_front();
        report_field("key_echo", 64'(want.key_echo), 64'(got.key_echo));
        report_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
        report_field("sample_sum", want.sample_sum, got.sample_sum);
        report_field("low_threshold", 64'(want.low_threshold), 64'(got.low_threshold));
        report_field("high_threshold", 64'(want.high_threshold), 64'(got.high_threshold));
        report_field("sets_full", 64'(want.sets_full), 64'(got.sets_full));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else                                    stall_cycles <= stall_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned k;
    int unsigned j;
    rst_ni         = 1'b0;
    start          = 1'b0;
    key_i          = '0;
    sample_i       = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    for (k = 0; k < NUM_KEYS; k++) begin
      seen_sum[k]   = '0;
      seen_count[k] = '0;
      for (j = 0; j < K_SLOTS; j++) begin
        small_slots[k][j] = '0;
        large_slots[k][j] = '0;
      end
    end

    directed_rows = '{
      '{4'd0,  32'd0,          1'b1, '{4'd0, 32'd1, 64'd0, 32'd0, 32'd0, 1'b0}},
      '{4'd15, 32'hFFFF_FFFF,  1'b1,
        '{4'd15, 32'd1, 64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
      '{4'd15, 32'd0,          1'b0, '0},
      // key 3 fill with paired duplicates so both scans see ties
      '{4'd3,  32'd5,          1'b0, '0},
      '{4'd3,  32'd5,          1'b0, '0},
      '{4'd3,  32'd9,          1'b0, '0},
      '{4'd3,  32'd9,          1'b0, '0},
      '{4'd3,  32'd1,          1'b0, '0},
      '{4'd3,  32'd1,          1'b0, '0},
      '{4'd3,  32'd7,          1'b0, '0},
      '{4'd3,  32'd7,          1'b1, '{4'd3, 32'd8, 64'd44, 32'd9, 32'd1, 1'b1}},
      '{4'd3,  32'd1,          1'b0, '0},  // equal to large-set minimum
      '{4'd3,  32'd9,          1'b0, '0},  // equal to small-set maximum
      '{4'd3,  32'd0,          1'b0, '0},
      '{4'd3,  32'hFFFF_FFFF,  1'b0, '0},
      '{4'd5,  32'h5555_5555,  1'b0, '0},
      '{4'd5,  32'hAAAA_AAAA,  1'b0, '0},
      '{4'd10, 32'd1,          1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].key, directed_rows[r].sample,
                directed_rows[r].typed, directed_rows[r].want);
      idle_cycles($urandom_range(0, 3) == 0 ? $urandom_range(1, 25) : 0);
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 16);
      for (j = 0; j < burst && sent < RANDOM_WORDS; j++) begin
        send_word(pick_key(), pick_sample(), 1'b0, '0);
        sent++;
      end
      // gaps shorter than the scan land on every phase of busy
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 4);
        2:       gap = $urandom_range(5, 22);
        default: gap = $urandom_range(23, 40);
      endcase
      idle_cycles(gap);
    end
    start <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lkt_pkg.sv
rtl/core/lkt_stat_unit.sv
rtl/core/lkt_set_unit.sv
rtl/core/latency_topk_tracker_core.sv
rtl/core/lkt_checker.sv
tb/latency_topk_tracker_core_tb.sv
